// ===== rtl/core/pdes_pkg.sv =====
`timescale 1ns / 1ps
package pdes_pkg;

   localparam int LEADING_DEFAULT = 8;
   localparam int QUEUE_DEPTH     = 4;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int OUT_IDX_W       = 3;

   localparam logic [7:0] GAP_HIGH_RESET = 8'd63;

   typedef enum logic [2:0] {
      REG_MIN_ET_FIRST        = 3'd0,
      REG_MIN_ET_SECOND       = 3'd1,
      REG_ABS_ETA_LOW_FIRST   = 3'd2,
      REG_ABS_ETA_HIGH_FIRST  = 3'd3,
      REG_ABS_ETA_LOW_SECOND  = 3'd4,
      REG_ABS_ETA_HIGH_SECOND = 3'd5,
      REG_GAP_LOW             = 3'd6,
      REG_GAP_HIGH            = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [9:0]        energy;
      logic signed [7:0] eta_pos;
      logic              list_end;
   } req_type;

   typedef struct packed {
      logic              is_pair;
      logic [2:0]        first_index;
      logic [2:0]        second_index;
      logic [9:0]        first_energy;
      logic signed [7:0] first_eta;
      logic [9:0]        second_energy;
      logic signed [7:0] second_eta;
      logic [7:0]        separation;
      logic              decision;
      logic              run_end;
   } rsp_type;

   typedef struct packed {
      logic [9:0] min_et_first;
      logic [9:0] min_et_second;
      logic [6:0] abs_eta_low_first;
      logic [6:0] abs_eta_high_first;
      logic [6:0] abs_eta_low_second;
      logic [6:0] abs_eta_high_second;
      logic [7:0] gap_low;
      logic [7:0] gap_high;
   } cfg_type;

   typedef struct packed {
      logic [9:0]        energy;
      logic signed [7:0] eta;
   } obj_type;

   typedef struct packed {
      obj_type obj;
      logic    pass_first;
      logic    pass_second;
      logic    keep;
      logic    list_end;
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE_I,
      ST_TAKE_I,
      ST_SCAN,
      ST_SUMMARY
   } back_state_type;

endpackage

// ===== rtl/core/pdes_front.sv =====
`timescale 1ns / 1ps
module pdes_front
   import pdes_pkg::*;
#(
   parameter int LEADING = LEADING_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic        q_full,
   output logic        q_push,
   output q_entry_type q_entry
);

   localparam int CNT_W = $clog2(LEADING + 1);
   localparam logic [CNT_W-1:0] LEAD_CNT = CNT_W'(LEADING);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             keep;
   logic [7:0]       abs_eta;
   logic [7:0]       lo1, hi1, lo2, hi2;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign keep      = cnt_ff < LEAD_CNT;
   assign abs_eta   = req_data.eta_pos[7] ? 8'(-req_data.eta_pos) : 8'(req_data.eta_pos);

   assign lo1 = {1'b0, cfg.abs_eta_low_first};
   assign hi1 = {1'b0, cfg.abs_eta_high_first};
   assign lo2 = {1'b0, cfg.abs_eta_low_second};
   assign hi2 = {1'b0, cfg.abs_eta_high_second};

   always_comb begin
      q_entry.obj.energy = req_data.energy;
      q_entry.obj.eta    = req_data.eta_pos;
      q_entry.pass_first = (req_data.energy >= cfg.min_et_first) &&
                           (abs_eta >= lo1) && (abs_eta <= hi1);
      q_entry.pass_second = (req_data.energy >= cfg.min_et_second) &&
                            (abs_eta >= lo2) && (abs_eta <= hi2);
      q_entry.keep     = keep;
      q_entry.list_end = req_data.list_end;
   end

   assign q_push = accept && (keep || req_data.list_end);

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_data.list_end) begin
            cnt_in = '0;
         end else if (keep) begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== rtl/core/pdes_queue.sv =====
`timescale 1ns / 1ps
module pdes_queue
   import pdes_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type push_data,
   input  logic        pop,
   output q_entry_type pop_data,
   output logic        full,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   q_entry_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == DEPTH_CNT;
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : PTR_W'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/pdes_back.sv =====
`timescale 1ns / 1ps
module pdes_back
   import pdes_pkg::*;
#(
   parameter int LEADING = LEADING_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  q_entry_type q_entry,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (LEADING > 1) ? $clog2(LEADING) : 1;
   localparam int CNT_W = $clog2(LEADING + 1);

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] pendj_ff, pendj_in;
   logic             pend_ff, pend_in;
   logic             any_ff, any_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [LEADING-1:0] pass1_ff, pass2_ff;
   obj_type            mem [LEADING];
   obj_type            rd_ff;
   obj_type            first_ff;
   logic [CNT_W-1:0]   first_idx_ff;

   logic             wr_en, rd_en, take_first, load_out, can_load, hit;
   logic [IDX_W-1:0] rd_addr;
   logic [8:0]       diff, abs_diff;
   logic [7:0]       sep;
   logic [CNT_W+2:0] idx_first_ext, idx_second_ext;

   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign diff     = {first_ff.eta[7], first_ff.eta} - {rd_ff.eta[7], rd_ff.eta};
   assign abs_diff = diff[8] ? 9'(-diff) : diff;
   assign sep      = abs_diff[7:0];
   assign hit      = (sep >= cfg.gap_low) && (sep <= cfg.gap_high);

   assign idx_first_ext  = {3'b000, first_idx_ff};
   assign idx_second_ext = {3'b000, pendj_ff};

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pend_in     = pend_ff;
      pendj_in    = pendj_ff;
      any_in      = any_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = i_ff[IDX_W-1:0];
      take_first  = 1'b0;
      load_out    = 1'b0;
      rsp_data_in = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_entry.keep) begin
                  wr_en  = 1'b1;
                  cnt_in = CNT_W'(cnt_ff + 1'b1);
               end
               if (q_entry.list_end) begin
                  i_in     = '0;
                  state_in = ST_ISSUE_I;
               end
            end
         end
         ST_ISSUE_I: begin
            if (i_ff >= cnt_ff) begin
               state_in = ST_SUMMARY;
            end else if (!pass1_ff[i_ff[IDX_W-1:0]]) begin
               i_in = CNT_W'(i_ff + 1'b1);
            end else begin
               rd_en    = 1'b1;
               j_in     = CNT_W'(i_ff + 1'b1);
               pend_in  = 1'b0;
               state_in = ST_TAKE_I;
            end
         end
         ST_TAKE_I: begin
            take_first = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (!pend_ff || can_load) begin
               if (pend_ff && hit) begin
                  load_out                  = 1'b1;
                  any_in                    = 1'b1;
                  rsp_data_in.is_pair       = 1'b1;
                  rsp_data_in.first_index   = idx_first_ext[OUT_IDX_W-1:0];
                  rsp_data_in.second_index  = idx_second_ext[OUT_IDX_W-1:0];
                  rsp_data_in.first_energy  = first_ff.energy;
                  rsp_data_in.first_eta     = first_ff.eta;
                  rsp_data_in.second_energy = rd_ff.energy;
                  rsp_data_in.second_eta    = rd_ff.eta;
                  rsp_data_in.separation    = sep;
                  rsp_data_in.decision      = 1'b1;
               end
               if (j_ff < cnt_ff) begin
                  pend_in  = pass2_ff[j_ff[IDX_W-1:0]];
                  rd_en    = pass2_ff[j_ff[IDX_W-1:0]];
                  rd_addr  = j_ff[IDX_W-1:0];
                  pendj_in = j_ff;
                  j_in     = CNT_W'(j_ff + 1'b1);
               end else begin
                  pend_in  = 1'b0;
                  i_in     = CNT_W'(i_ff + 1'b1);
                  state_in = ST_ISSUE_I;
               end
            end
         end
         ST_SUMMARY: begin
            if (can_load) begin
               load_out             = 1'b1;
               rsp_data_in.decision = any_ff;
               rsp_data_in.run_end  = 1'b1;
               cnt_in               = '0;
               any_in               = 1'b0;
               state_in             = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase

      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         pend_ff      <= 1'b0;
         pendj_ff     <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         pend_ff      <= pend_in;
         pendj_ff     <= pendj_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (take_first) begin
         first_ff     <= rd_ff;
         first_idx_ff <= i_ff;
      end
      if (wr_en) begin
         mem[cnt_ff[IDX_W-1:0]]      <= q_entry.obj;
         pass1_ff[cnt_ff[IDX_W-1:0]] <= q_entry.pass_first;
         pass2_ff[cnt_ff[IDX_W-1:0]] <= q_entry.pass_second;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/core/pairwise_delta_eta_selector_unit.sv =====
`timescale 1ns / 1ps
// Pairwise eta-gap selector. Objects stream in as req words, one per cycle while
// the four-entry queue has room; the front applies the per-object Et and |eta|
// cuts and keeps the first LEADING objects of each list. On the list_end word the
// back walks all pairs i<j out of its single-read-port object memory: each object
// that passes the first cut is read and latched as the first of a pair, then every
// later object is scanned and those that pass the second cut are read and checked
// against the gap window; objects failing the first cut are skipped, and the walk
// ends in a summary state. A stalled rsp holds the walk. Pair words come out in
// outer-i, inner-j order, followed by one summary word with run_end set. The front
// keeps loading the next list during a walk until the queue fills. Registers are to
// be written over the APB port only while idle; the block itself does not enforce it.
module pairwise_delta_eta_selector_unit
   import pdes_pkg::*;
#(
   parameter int LEADING = LEADING_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam cfg_type CFG_RESET = cfg_type'({56'd0, GAP_HIGH_RESET});

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          csr_write;

   logic          q_push, q_pop, q_full, q_empty;
   q_entry_type   q_push_data, q_pop_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_sel   = reg_index_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (reg_sel)
         REG_MIN_ET_FIRST: begin
            prdata = CSR_DATA_W'(cfg_ff.min_et_first);
            if (csr_write) cfg_in.min_et_first = pwdata[9:0];
         end
         REG_MIN_ET_SECOND: begin
            prdata = CSR_DATA_W'(cfg_ff.min_et_second);
            if (csr_write) cfg_in.min_et_second = pwdata[9:0];
         end
         REG_ABS_ETA_LOW_FIRST: begin
            prdata = CSR_DATA_W'(cfg_ff.abs_eta_low_first);
            if (csr_write) cfg_in.abs_eta_low_first = pwdata[6:0];
         end
         REG_ABS_ETA_HIGH_FIRST: begin
            prdata = CSR_DATA_W'(cfg_ff.abs_eta_high_first);
            if (csr_write) cfg_in.abs_eta_high_first = pwdata[6:0];
         end
         REG_ABS_ETA_LOW_SECOND: begin
            prdata = CSR_DATA_W'(cfg_ff.abs_eta_low_second);
            if (csr_write) cfg_in.abs_eta_low_second = pwdata[6:0];
         end
         REG_ABS_ETA_HIGH_SECOND: begin
            prdata = CSR_DATA_W'(cfg_ff.abs_eta_high_second);
            if (csr_write) cfg_in.abs_eta_high_second = pwdata[6:0];
         end
         REG_GAP_LOW: begin
            prdata = CSR_DATA_W'(cfg_ff.gap_low);
            if (csr_write) cfg_in.gap_low = pwdata[7:0];
         end
         REG_GAP_HIGH: begin
            prdata = CSR_DATA_W'(cfg_ff.gap_high);
            if (csr_write) cfg_in.gap_high = pwdata[7:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdes_front #(
      .LEADING (LEADING)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_push_data)
   );

   pdes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pdes_back #(
      .LEADING (LEADING)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_entry   (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("queue full and empty together");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

   a_pair_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_pair) |-> (rsp_data.decision && !rsp_data.run_end))
      else $error("pair word with bad flags");

   a_summary_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.run_end) |-> (!rsp_data.is_pair &&
         rsp_data.separation == 8'd0 && rsp_data.first_energy == 10'd0))
      else $error("summary word carries pair data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule
